@@ sv/fhc_pkg.sv @@
// Shared types, constants and CRC helper for the frame header checker.
`default_nettype none
package fhc_pkg;

	localparam int HEADER_BYTES = 48;
	localparam int HDR_IDX_BITS = $clog2(HEADER_BYTES);
	localparam int OFS_HCRC     = 40;
	localparam int OFS_RSVD     = 44;
	localparam int OFS_META     = 28;
	localparam int OFS_PAY      = 32;
	localparam int OFS_BCRC     = 36;
	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_IDX_BITS  = 2;
	localparam int TDATA_OUT_BITS = 232;

	localparam logic [31:0] CRC_POLY = 32'hedb88320;
	localparam logic [31:0] CRC_ONES = 32'hffffffff;
	localparam logic [15:0] VERSION_ONE = 16'h0001;
	localparam logic [15:0] FLAG_VALID_MASK = 16'h0003;
	localparam logic [15:0] FLAG_REQUIRED = 16'h0001;
	localparam logic [15:0] FLAG_PAYLOAD = 16'h0002;

	localparam logic [CFG_IDX_BITS-1:0] REG_MAGIC     = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_TYPE_MASK = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_META  = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_BODY  = 2'd3;

	localparam logic [31:0] RST_MAGIC     = 32'd0;
	localparam logic [15:0] RST_TYPE_MASK = 16'd1023;
	localparam logic [23:0] RST_MAX_META  = 24'd65536;
	localparam logic [23:0] RST_MAX_BODY  = 24'hffffff;

	localparam logic [3:0] ST_OK          = 4'd0;
	localparam logic [3:0] ST_INCOMPLETE  = 4'd1;
	localparam logic [3:0] ST_MAGIC       = 4'd2;
	localparam logic [3:0] ST_VERSION     = 4'd3;
	localparam logic [3:0] ST_HDRSIZE     = 4'd4;
	localparam logic [3:0] ST_HDRCRC      = 4'd5;
	localparam logic [3:0] ST_TYPE        = 4'd6;
	localparam logic [3:0] ST_FLAGS       = 4'd7;
	localparam logic [3:0] ST_RESERVED    = 4'd8;
	localparam logic [3:0] ST_META        = 4'd9;
	localparam logic [3:0] ST_BODY        = 4'd10;
	localparam logic [3:0] ST_LENGTH      = 4'd11;
	localparam logic [3:0] ST_PAYLOADFLAG = 4'd12;
	localparam logic [3:0] ST_BODYCRC     = 4'd13;

	typedef struct packed {
		logic [31:0] magic_word;
		logic [15:0] known_type_mask;
		logic [23:0] max_metadata_bytes;
		logic [23:0] max_body_bytes;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_frame;
	} in_t;

	typedef struct packed {
		logic [31:0] pay_len;
		logic [31:0] meta_len;
		logic signed [63:0] sim_time_ns;
		logic [63:0] sequence_number;
		logic [15:0] frame_flags;
		logic [15:0] msg_kind;
		logic [3:0]  status;
	} result_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
		logic [31:0] c;
		c = crc_in ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
		end
		return c;
	endfunction

endpackage
`default_nettype wire

@@ sv/fhc_in_reg.sv @@
// Input register stage for the byte stream.
`default_nettype none
module fhc_in_reg (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire fhc_pkg::in_t in_data,
	input  wire logic        consume,
	output      logic        valid_s1,
	output      fhc_pkg::in_t data_s1
);

	assign in_ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

endmodule
`default_nettype wire

@@ sv/fhc_core.sv @@
// Frame state, header capture, CRC update and verdict logic.
`default_nettype none
module fhc_core #(
	parameter int COUNT_BITS = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire fhc_pkg::cfg_t   cfg,
	input  wire logic            valid_s1,
	input  wire fhc_pkg::in_t    data_s1,
	input  wire logic            out_ready,
	output      logic            consume,
	output      logic            push,
	output      fhc_pkg::result_t res
);

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] count_nx;
	logic [31:0]           hcrc_q;
	logic [31:0]           bcrc_q;
	logic [31:0]           hcrc_nx;
	logic [31:0]           bcrc_nx;
	logic [7:0]            hdr_q  [fhc_pkg::HEADER_BYTES];
	logic [7:0]            hdr_nx [fhc_pkg::HEADER_BYTES];
	logic                  in_hdr;
	logic                  in_hcrc_word;
	logic [fhc_pkg::HDR_IDX_BITS-1:0] hdr_idx;

	logic [31:0] magic_f;
	logic [15:0] version_f;
	logic [15:0] hsize_f;
	logic [31:0] hcrc_f;
	logic [31:0] rsvd_f;
	logic [31:0] bcrc_f;
	logic [33:0] total;
	logic [32:0] body_sum;
	logic        saturated;
	logic        complete;
	logic [3:0]  status;
	fhc_pkg::result_t fld;

	assign consume = valid_s1 && (!data_s1.end_of_frame || out_ready);
	assign push    = consume && data_s1.end_of_frame;

	assign in_hdr       = count_q < COUNT_BITS'(fhc_pkg::HEADER_BYTES);
	assign in_hcrc_word = (count_q >= COUNT_BITS'(fhc_pkg::OFS_HCRC))
		&& (count_q < COUNT_BITS'(fhc_pkg::OFS_HCRC + 4));
	assign hdr_idx      = count_q[fhc_pkg::HDR_IDX_BITS-1:0];

	assign count_nx = (count_q == CNT_MAX) ? count_q : count_q + COUNT_BITS'(1);
	assign hcrc_nx  = !in_hdr ? hcrc_q
		: fhc_pkg::crc_byte(hcrc_q, in_hcrc_word ? 8'd0 : data_s1.data_byte);
	assign bcrc_nx  = in_hdr ? bcrc_q : fhc_pkg::crc_byte(bcrc_q, data_s1.data_byte);

	always_comb begin
		for (int k = 0; k < fhc_pkg::HEADER_BYTES; k++) begin
			hdr_nx[k] = (in_hdr && hdr_idx == fhc_pkg::HDR_IDX_BITS'(k))
				? data_s1.data_byte : hdr_q[k];
		end
	end

	always_ff @(posedge clk) begin
		if (consume && in_hdr) begin
			hdr_q[hdr_idx] <= data_s1.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			hcrc_q  <= fhc_pkg::CRC_ONES;
			bcrc_q  <= fhc_pkg::CRC_ONES;
		end else if (consume) begin
			if (data_s1.end_of_frame) begin
				count_q <= '0;
				hcrc_q  <= fhc_pkg::CRC_ONES;
				bcrc_q  <= fhc_pkg::CRC_ONES;
			end else begin
				count_q <= count_nx;
				hcrc_q  <= hcrc_nx;
				bcrc_q  <= bcrc_nx;
			end
		end
	end

	assign magic_f   = {hdr_nx[3], hdr_nx[2], hdr_nx[1], hdr_nx[0]};
	assign version_f = {hdr_nx[5], hdr_nx[4]};
	assign hsize_f   = {hdr_nx[7], hdr_nx[6]};
	assign hcrc_f    = {hdr_nx[fhc_pkg::OFS_HCRC+3], hdr_nx[fhc_pkg::OFS_HCRC+2],
		hdr_nx[fhc_pkg::OFS_HCRC+1], hdr_nx[fhc_pkg::OFS_HCRC]};
	assign rsvd_f    = {hdr_nx[fhc_pkg::OFS_RSVD+3], hdr_nx[fhc_pkg::OFS_RSVD+2],
		hdr_nx[fhc_pkg::OFS_RSVD+1], hdr_nx[fhc_pkg::OFS_RSVD]};
	assign bcrc_f    = {hdr_nx[fhc_pkg::OFS_BCRC+3], hdr_nx[fhc_pkg::OFS_BCRC+2],
		hdr_nx[fhc_pkg::OFS_BCRC+1], hdr_nx[fhc_pkg::OFS_BCRC]};

	always_comb begin
		fld.status          = fhc_pkg::ST_OK;
		fld.msg_kind        = {hdr_nx[9], hdr_nx[8]};
		fld.frame_flags     = {hdr_nx[11], hdr_nx[10]};
		fld.sequence_number = {hdr_nx[19], hdr_nx[18], hdr_nx[17], hdr_nx[16],
			hdr_nx[15], hdr_nx[14], hdr_nx[13], hdr_nx[12]};
		fld.sim_time_ns     = {hdr_nx[27], hdr_nx[26], hdr_nx[25], hdr_nx[24],
			hdr_nx[23], hdr_nx[22], hdr_nx[21], hdr_nx[20]};
		fld.meta_len        = {hdr_nx[fhc_pkg::OFS_META+3], hdr_nx[fhc_pkg::OFS_META+2],
			hdr_nx[fhc_pkg::OFS_META+1], hdr_nx[fhc_pkg::OFS_META]};
		fld.pay_len         = {hdr_nx[fhc_pkg::OFS_PAY+3], hdr_nx[fhc_pkg::OFS_PAY+2],
			hdr_nx[fhc_pkg::OFS_PAY+1], hdr_nx[fhc_pkg::OFS_PAY]};
	end

	assign total     = 34'(fhc_pkg::HEADER_BYTES) + 34'(fld.meta_len)
		+ 34'(fld.pay_len);
	assign body_sum  = 33'(fld.meta_len) + 33'(fld.pay_len);
	assign saturated = count_nx == CNT_MAX;
	assign complete  = count_nx >= COUNT_BITS'(fhc_pkg::HEADER_BYTES);

	always_comb begin
		if (magic_f != cfg.magic_word) begin
			status = fhc_pkg::ST_MAGIC;
		end else if (version_f != fhc_pkg::VERSION_ONE) begin
			status = fhc_pkg::ST_VERSION;
		end else if (hsize_f != 16'(fhc_pkg::HEADER_BYTES)) begin
			status = fhc_pkg::ST_HDRSIZE;
		end else if ((hcrc_nx ^ fhc_pkg::CRC_ONES) != hcrc_f) begin
			status = fhc_pkg::ST_HDRCRC;
		end else if (fld.msg_kind[15:4] != 12'd0
			|| !cfg.known_type_mask[fld.msg_kind[3:0]]) begin
			status = fhc_pkg::ST_TYPE;
		end else if ((fld.frame_flags & ~fhc_pkg::FLAG_VALID_MASK) != 16'd0
			|| (fld.frame_flags & fhc_pkg::FLAG_REQUIRED) == 16'd0) begin
			status = fhc_pkg::ST_FLAGS;
		end else if (rsvd_f != 32'd0) begin
			status = fhc_pkg::ST_RESERVED;
		end else if (fld.meta_len > 32'(cfg.max_metadata_bytes)) begin
			status = fhc_pkg::ST_META;
		end else if (body_sum > 33'(cfg.max_body_bytes)) begin
			status = fhc_pkg::ST_BODY;
		end else if (saturated || 34'(count_nx) != total) begin
			status = fhc_pkg::ST_LENGTH;
		end else if (((fld.frame_flags & fhc_pkg::FLAG_PAYLOAD) != 16'd0)
			!= (fld.pay_len != 32'd0)) begin
			status = fhc_pkg::ST_PAYLOADFLAG;
		end else if ((bcrc_nx ^ fhc_pkg::CRC_ONES) != bcrc_f) begin
			status = fhc_pkg::ST_BODYCRC;
		end else begin
			status = fhc_pkg::ST_OK;
		end
	end

	always_comb begin
		if (complete) begin
			res        = fld;
			res.status = status;
		end else begin
			res        = '0;
			res.status = fhc_pkg::ST_INCOMPLETE;
		end
	end

	a_count_advances: assert property (@(posedge clk) disable iff (!arst_n)
		consume && !data_s1.end_of_frame |=> count_q != '0)
		else $error("byte count did not advance");

	a_frame_clears: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> count_q == '0 && hcrc_q == fhc_pkg::CRC_ONES
			&& bcrc_q == fhc_pkg::CRC_ONES)
		else $error("frame state not cleared after last byte");

	a_incomplete_zero: assert property (@(posedge clk) disable iff (!arst_n)
		push && res.status == fhc_pkg::ST_INCOMPLETE |->
			res.msg_kind == 16'd0 && res.pay_len == 32'd0)
		else $error("incomplete frame carries header fields");

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_ready && valid_s1)
		else $error("verdict produced without room in result register");

endmodule
`default_nettype wire

@@ sv/fhc_out_reg.sv @@
// Result register holding one verdict until it is taken.
`default_nettype none
module fhc_out_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire fhc_pkg::result_t res,
	output      logic             out_ready,
	output      logic             out_valid,
	input  wire logic             out_take,
	output      fhc_pkg::result_t out_data
);

	logic valid_q;

	assign out_ready = !valid_q || out_take;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_ready) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push && out_ready) begin
			out_data <= res;
		end
	end

endmodule
`default_nettype wire

@@ sv/frame_header_checker_unit.sv @@
// Top level of the frame header checker: configuration registers and stage wiring.
// A last byte passes the input register and then the result register before its verdict is on m_tvalid.
// Throughput: one byte per cycle; the input register advances whenever the result
// register has room, and only last bytes need that room.
// Reset: arst_n clears the byte count, both CRC runs, the stage valids and the
// configuration registers to their defaults; the header bytes are not cleared.
`default_nettype none
module frame_header_checker_unit #(
	parameter int COUNT_BITS = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output      logic                                 s_tready,
	input  wire logic [7:0]                           s_tdata,  // data_byte[7:0]
	input  wire logic                                 s_tlast,
	output      logic                                 m_tvalid,
	input  wire logic                                 m_tready,
	// status[3:0], msg_kind[19:4], frame_flags[35:20], sequence_number[99:36],
	// sim_time_ns[163:100], meta_len[195:164], pay_len[227:196], zero pad
	output      logic [fhc_pkg::TDATA_OUT_BITS-1:0]   m_tdata,
	input  wire logic                                 cfg_we,
	input  wire logic [fhc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  wire logic [fhc_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

	fhc_pkg::cfg_t    cfg_q;
	fhc_pkg::in_t     in_data;
	fhc_pkg::in_t     data_s1;
	fhc_pkg::result_t res;
	fhc_pkg::result_t out_data;
	logic             valid_s1;
	logic             consume;
	logic             push;
	logic             out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic_word         <= fhc_pkg::RST_MAGIC;
			cfg_q.known_type_mask    <= fhc_pkg::RST_TYPE_MASK;
			cfg_q.max_metadata_bytes <= fhc_pkg::RST_MAX_META;
			cfg_q.max_body_bytes     <= fhc_pkg::RST_MAX_BODY;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fhc_pkg::REG_MAGIC: begin
					cfg_q.magic_word <= cfg_wdata;
				end
				fhc_pkg::REG_TYPE_MASK: begin
					cfg_q.known_type_mask <= cfg_wdata[15:0];
				end
				fhc_pkg::REG_MAX_META: begin
					cfg_q.max_metadata_bytes <= cfg_wdata[23:0];
				end
				fhc_pkg::REG_MAX_BODY: begin
					cfg_q.max_body_bytes <= cfg_wdata[23:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign in_data.data_byte    = s_tdata;
	assign in_data.end_of_frame = s_tlast;

	fhc_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_data  (in_data),
		.consume  (consume),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	fhc_core #(
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.valid_s1  (valid_s1),
		.data_s1   (data_s1),
		.out_ready (out_ready),
		.consume   (consume),
		.push      (push),
		.res       (res)
	);

	fhc_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.res       (res),
		.out_ready (out_ready),
		.out_valid (m_tvalid),
		.out_take  (m_tready),
		.out_data  (out_data)
	);

	assign m_tdata = {4'd0, out_data};

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// Testbench for the frame header checker: drives byte frames and checks every verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fhc_pkg::*;

	localparam int COUNT_BITS = 16;
	localparam logic [31:0] COUNT_TOP = 32'((64'd1 << COUNT_BITS) - 64'd1);
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int LONG_HOLD = 300;

	class verdict_predictor;
		logic [31:0] magic;
		logic [15:0] type_mask;
		logic [23:0] max_meta;
		logic [23:0] max_body;
		logic [31:0] count_top;
		logic [31:0] byte_cnt;
		logic [7:0]  hdr [HEADER_BYTES];
		logic [31:0] hdr_crc;
		logic [31:0] body_crc;
		result_t     verdicts_due [$];
		int          errors;

		function new(logic [31:0] top);
			count_top = top;
			magic = RST_MAGIC;
			type_mask = RST_TYPE_MASK;
			max_meta = RST_MAX_META;
			max_body = RST_MAX_BODY;
			byte_cnt = '0;
			hdr_crc = CRC_ONES;
			body_crc = CRC_ONES;
			errors = 0;
			foreach (hdr[i]) hdr[i] = 8'h00;
		endfunction

		static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] d);
			logic [31:0] r;
			logic fb;
			r = c;
			for (int k = 0; k < 8; k++) begin
				fb = r[0] ^ d[k];
				r = {1'b0, r[31:1]} ^ (fb ? CRC_POLY : 32'h0);
			end
			return r;
		endfunction

		function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] v);
			case (idx)
				REG_MAGIC: magic = v;
				REG_TYPE_MASK: type_mask = v[15:0];
				REG_MAX_META: max_meta = v[23:0];
				REG_MAX_BODY: max_body = v[23:0];
				default: ;
			endcase
		endfunction

		function logic [63:0] le_field(int ofs, int n);
			logic [63:0] v;
			v = '0;
			for (int i = n - 1; i >= 0; i--) v = {v[55:0], hdr[ofs+i]};
			return v;
		endfunction

		task report(string what);
			$display("ERROR at %0t: %s", $time, what);
			errors++;
		endtask

		function void take_byte(logic [7:0] b, logic last);
			result_t r;
			logic [63:0] total;
			logic [15:0] flg;
			logic [31:0] meta;
			logic [31:0] pay;
			if (byte_cnt < HEADER_BYTES) begin
				hdr[byte_cnt] = b;
				if (byte_cnt >= OFS_HCRC && byte_cnt < OFS_HCRC + 4)
					hdr_crc = crc_step(hdr_crc, 8'h00);
				else
					hdr_crc = crc_step(hdr_crc, b);
			end else begin
				body_crc = crc_step(body_crc, b);
			end
			if (byte_cnt < count_top) byte_cnt++;
			if (!last) return;
			r = '0;
			if (byte_cnt < HEADER_BYTES) begin
				r.status = ST_INCOMPLETE;
			end else begin
				r.msg_kind = 16'(le_field(8, 2));
				r.frame_flags = 16'(le_field(10, 2));
				r.sequence_number = le_field(12, 8);
				r.sim_time_ns = le_field(20, 8);
				r.meta_len = 32'(le_field(OFS_META, 4));
				r.pay_len = 32'(le_field(OFS_PAY, 4));
				flg = r.frame_flags;
				meta = r.meta_len;
				pay = r.pay_len;
				total = 64'(HEADER_BYTES) + 64'(meta) + 64'(pay);
				if (le_field(0, 4) != 64'(magic))
					r.status = ST_MAGIC;
				else if (le_field(4, 2) != 64'(VERSION_ONE))
					r.status = ST_VERSION;
				else if (le_field(6, 2) != 64'(HEADER_BYTES))
					r.status = ST_HDRSIZE;
				else if (64'(hdr_crc ^ CRC_ONES) != le_field(OFS_HCRC, 4))
					r.status = ST_HDRCRC;
				else if (r.msg_kind >= 16 || !type_mask[r.msg_kind[3:0]])
					r.status = ST_TYPE;
				else if ((flg & ~FLAG_VALID_MASK) != 0 || (flg & FLAG_REQUIRED) == 0)
					r.status = ST_FLAGS;
				else if (le_field(OFS_RSVD, 4) != 0)
					r.status = ST_RESERVED;
				else if (meta > max_meta)
					r.status = ST_META;
				else if (64'(meta) + 64'(pay) > 64'(max_body))
					r.status = ST_BODY;
				else if (byte_cnt == count_top || 64'(byte_cnt) != total)
					r.status = ST_LENGTH;
				else if (((flg & FLAG_PAYLOAD) != 0) != (pay != 0))
					r.status = ST_PAYLOADFLAG;
				else if (64'(body_crc ^ CRC_ONES) != le_field(OFS_BCRC, 4))
					r.status = ST_BODYCRC;
				else
					r.status = ST_OK;
			end
			verdicts_due = {verdicts_due, r};
			byte_cnt = '0;
			hdr_crc = CRC_ONES;
			body_crc = CRC_ONES;
		endfunction

		task check_verdict(logic [TDATA_OUT_BITS-1:0] word);
			result_t got;
			result_t want;
			if (verdicts_due.size() == 0) begin
				report($sformatf("verdict with none expected, status %0d", word[3:0]));
				return;
			end
			want = verdicts_due.pop_front();
			got = word[$bits(result_t)-1:0];
			if (got.status !== want.status)
				report($sformatf("status got %0d want %0d", got.status, want.status));
			if (got.msg_kind !== want.msg_kind)
				report($sformatf("msg_kind got %h want %h", got.msg_kind,
					want.msg_kind));
			if (got.frame_flags !== want.frame_flags)
				report($sformatf("frame_flags got %h want %h", got.frame_flags,
					want.frame_flags));
			if (got.sequence_number !== want.sequence_number)
				report($sformatf("sequence_number got %h want %h", got.sequence_number,
					want.sequence_number));
			if (got.sim_time_ns !== want.sim_time_ns)
				report($sformatf("sim_time_ns got %0d want %0d", got.sim_time_ns,
					want.sim_time_ns));
			if (got.meta_len !== want.meta_len)
				report($sformatf("meta_len got %h want %h", got.meta_len,
					want.meta_len));
			if (got.pay_len !== want.pay_len)
				report($sformatf("pay_len got %h want %h", got.pay_len,
					want.pay_len));
			if (word[TDATA_OUT_BITS-1:$bits(result_t)] !== '0)
				report("pad bits of m_tdata not zero");
		endtask
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        s_tvalid;
	logic                        s_tready;
	logic [7:0]                  s_tdata;
	logic                        s_tlast;
	logic                        m_tvalid;
	logic                        m_tready;
	logic [TDATA_OUT_BITS-1:0]   m_tdata;
	logic                        cfg_we;
	logic [CFG_IDX_BITS-1:0]     cfg_index;
	logic [CFG_DATA_BITS-1:0]    cfg_wdata;

	verdict_predictor sb;
	bit          gaps_on = 1'b1;
	bit          hold_req = 1'b0;
	int          stall_left;
	int unsigned cycle_count = 0;
	logic [7:0]  frame_q [$];
	int          phase_bytes;
	int          phase_frames;

	frame_header_checker_unit #(.COUNT_BITS(COUNT_BITS)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) sb.take_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) sb.check_verdict(m_tdata);
		end
	end

	initial begin
		m_tready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 7);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic logic [31:0] nonzero_word();
		logic [31:0] v;
		v = $urandom;
		if (v == 0) v = 32'h1;
		return v;
	endfunction

	function automatic void put_le(int ofs, int n, logic [63:0] v);
		for (int i = 0; i < n; i++) frame_q[ofs+i] = v[8*i +: 8];
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		if (gaps_on && $urandom_range(0, 9) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
		phase_bytes += frame_q.size();
		phase_frames++;
	endtask

	task automatic send_noise();
		int n;
		n = $urandom_range(1, 60);
		for (int i = 0; i < n; i++)
			send_byte(8'($urandom), (i == n - 1) || ($urandom_range(0, 15) == 0));
		phase_bytes += n;
		phase_frames++;
	endtask

	// ext 1 and 2 pick opposite extremes of the header fields
	task automatic build_frame(input logic [3:0] fault, input int lo, input int hi,
			input int ext);
		logic [31:0] magic_f;
		logic [31:0] meta;
		logic [31:0] pay;
		logic [31:0] hcrc;
		logic [31:0] bcrc;
		logic [31:0] rsvd;
		logic [15:0] ver;
		logic [15:0] hsize;
		logic [15:0] mtype;
		logic [15:0] flg;
		logic [63:0] seq;
		logic [63:0] simt;
		logic [7:0]  b;
		int len;
		int sent_len;
		frame_q.delete();
		if (fault == ST_INCOMPLETE) begin
			len = (ext == 1) ? 1 : (ext == 2) ? HEADER_BYTES - 1 :
				$urandom_range(1, HEADER_BYTES - 1);
			repeat (len) frame_q = {frame_q, 8'($urandom)};
			return;
		end
		if (hi > sb.max_body) hi = sb.max_body;
		if (lo > hi) lo = hi;
		len = $urandom_range(lo, hi);
		meta = $urandom_range(0, (len < sb.max_meta) ? len : sb.max_meta);
		pay = len - meta;
		magic_f = sb.magic;
		ver = VERSION_ONE;
		hsize = 16'(HEADER_BYTES);
		flg = FLAG_REQUIRED | ((pay != 0) ? FLAG_PAYLOAD : 16'h0);
		if (sb.type_mask == 0)
			mtype = 16'($urandom_range(0, 15));
		else
			do mtype = 16'($urandom_range(0, 15)); while (!sb.type_mask[mtype[3:0]]);
		seq = {$urandom, $urandom};
		simt = {$urandom, $urandom};
		rsvd = '0;
		if (ext == 1) begin
			seq = '1;
			simt = 64'h8000_0000_0000_0000;
		end else if (ext == 2) begin
			seq = '0;
			simt = 64'h7fff_ffff_ffff_ffff;
		end
		sent_len = len;
		case (fault)
			ST_MAGIC: magic_f ^= nonzero_word();
			ST_VERSION: ver ^= 16'($urandom_range(1, 65535));
			ST_HDRSIZE: hsize ^= 16'($urandom_range(1, 65535));
			ST_TYPE: begin
				if (ext != 0) mtype = 16'hffff;
				else if ($urandom_range(0, 1)) mtype = 16'($urandom);
				else mtype = 16'($urandom_range(0, 15));
			end
			ST_FLAGS: begin
				if ($urandom_range(0, 1)) flg |= 16'($urandom_range(1, 16383)) << 2;
				else flg &= ~FLAG_REQUIRED;
			end
			ST_RESERVED: rsvd = nonzero_word();
			ST_META: begin
				if (ext != 0) meta = '1;
				else meta = 32'(sb.max_meta) + 32'($urandom_range(1, 1000));
			end
			ST_BODY: begin
				if (ext != 0) begin
					if (sb.max_meta != 0) meta = 32'h1;
					pay = '1;
				end else begin
					pay = 32'(sb.max_body) - meta + 32'($urandom_range(1, 1000));
				end
			end
			ST_LENGTH: begin
				if (len > 0 && $urandom_range(0, 1))
					sent_len = len - $urandom_range(1, (len < 4) ? len : 4);
				else
					sent_len = len + $urandom_range(1, 4);
			end
			ST_PAYLOADFLAG: flg ^= FLAG_PAYLOAD;
			default: ;
		endcase
		repeat (HEADER_BYTES) frame_q = {frame_q, 8'h00};
		bcrc = CRC_ONES;
		for (int i = 0; i < sent_len; i++) begin
			b = 8'($urandom);
			frame_q = {frame_q, b};
			bcrc = verdict_predictor::crc_step(bcrc, b);
		end
		bcrc ^= CRC_ONES;
		if (fault == ST_BODYCRC) bcrc ^= nonzero_word();
		put_le(0, 4, magic_f);
		put_le(4, 2, ver);
		put_le(6, 2, hsize);
		put_le(8, 2, mtype);
		put_le(10, 2, flg);
		put_le(12, 8, seq);
		put_le(20, 8, simt);
		put_le(OFS_META, 4, meta);
		put_le(OFS_PAY, 4, pay);
		put_le(OFS_BCRC, 4, bcrc);
		put_le(OFS_RSVD, 4, rsvd);
		hcrc = CRC_ONES;
		for (int i = 0; i < HEADER_BYTES; i++)
			hcrc = verdict_predictor::crc_step(hcrc,
				(i >= OFS_HCRC && i < OFS_HCRC + 4) ? 8'h00 : frame_q[i]);
		hcrc ^= CRC_ONES;
		if (fault == ST_HDRCRC) hcrc ^= nonzero_word();
		put_le(OFS_HCRC, 4, hcrc);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.verdicts_due.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_config(input logic [31:0] magic_v, input logic [31:0] mask_v,
			input logic [31:0] meta_v, input logic [31:0] body_v);
		logic [CFG_IDX_BITS-1:0] regs [4];
		logic [31:0] vals [4];
		regs = '{REG_MAGIC, REG_TYPE_MASK, REG_MAX_META, REG_MAX_BODY};
		vals = '{magic_v, mask_v, meta_v, body_v};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= regs[i];
			cfg_wdata <= vals[i];
			@(negedge clk);
			sb.set_reg(regs[i], vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic run_random(input int min_bytes, input int min_frames);
		int pick;
		logic [3:0] fault;
		phase_bytes = 0;
		phase_frames = 0;
		while (phase_bytes < min_bytes || phase_frames < min_frames) begin
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				send_noise();
			end else begin
				fault = (pick < 70) ? ST_OK : 4'($urandom_range(ST_INCOMPLETE, ST_BODYCRC));
				build_frame(fault, 0, ($urandom_range(0, 9) == 0) ? 200 : 40, 0);
				send_frame();
			end
		end
		wait_idle();
	endtask

	initial begin
		sb = new(COUNT_TOP);
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		build_frame(ST_OK, 0, 0, 1);
		send_frame();
		build_frame(ST_OK, 8, 8, 2);
		send_frame();
		build_frame(ST_INCOMPLETE, 0, 0, 1);
		send_frame();
		build_frame(ST_INCOMPLETE, 0, 0, 2);
		send_frame();
		for (int f = ST_MAGIC; f <= ST_BODYCRC; f++) begin
			build_frame(4'(f), 0, 0, (f % 2) + 1);
			send_frame();
		end
		wait_idle();

		set_config(nonzero_word(), 32'hffff | ($urandom << 16), 32'hffff_ffff, 32'hffff_ffff);
		hold_req = 1'b1;
		repeat (10) begin
			build_frame(ST_INCOMPLETE, 0, 0, 1);
			send_frame();
		end
		run_random(30, 1);

		set_config(32'hffff_ffff, 32'hffff_0000, 32'hff00_0000, 32'h5a00_0000);
		run_random(30, 1);

		set_config($urandom, $urandom, $urandom_range(0, 40) | ($urandom << 24),
			$urandom_range(0, 60) | ($urandom << 24));
		run_random(30, 1);

		gaps_on = 1'b0;
		set_config(RST_MAGIC, RST_TYPE_MASK, RST_MAX_META, RST_MAX_BODY);
		run_random(60, 1);

		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
